// File: rtl/core/cldf_pkg.sv
package cldf_pkg;

  // Result kinds as carried on the output tuser
  typedef enum logic [2:0] {
    KIND_BODY      = 3'd0,
    KIND_EMPTY     = 3'd1,
    KIND_LINE_LONG = 3'd2,
    KIND_BAD_VALUE = 3'd3,
    KIND_TOO_LARGE = 3'd4,
    KIND_NO_LENGTH = 3'd5,
    KIND_STREAM_END = 3'd6
  } kind_e;

  // Configuration register indexes
  localparam logic RegMaxBody = 1'b0;
  localparam logic RegMaxLine = 1'b1;

  localparam logic [31:0] MaxBodyReset = 32'h0400_0000;  // 64 MiB
  localparam logic [15:0] MaxLineReset = 16'h2000;       // 8 KiB

  // Characters the parser reacts to
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] CaseGap = 8'h20;

  // Length of the header name we look for
  localparam logic [3:0] NameLen = 4'd14;
  localparam logic [3:0] NamePosMax = 4'd15;

  // Value parsing phase
  typedef enum logic [1:0] {
    VP_SKIP   = 2'd0,  // skipping leading whitespace
    VP_SIGN   = 2'd1,  // sign taken, digits expected
    VP_DIGITS = 2'd2,  // inside the digit run
    VP_DONE   = 2'd3   // digit run finished
  } vphase_e;

  // Per-line parser state, apart from the accumulator
  typedef struct packed {
    logic       colon;
    logic [3:0] name_pos;
    logic       name_match;
    vphase_e    vphase;
    logic       vneg;
    logic       vdigit;
  } line_st_t;

  typedef struct packed {
    line_st_t st;
    logic     acc;   // a digit goes into the accumulator
  } feed_t;

  // Control towards the value accumulator
  typedef struct packed {
    logic       clear;
    logic       acc_en;
    logic [3:0] digit;
  } val_ctrl_t;

  // Status back from the value accumulator
  typedef struct packed {
    logic        overflow;
    logic        too_large;
    logic [31:0] value;
  } val_stat_t;

  // Lower-case "content-length", one character per position
  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h63;  // c
      4'd1:    c = 8'h6F;  // o
      4'd2:    c = 8'h6E;  // n
      4'd3:    c = 8'h74;  // t
      4'd4:    c = 8'h65;  // e
      4'd5:    c = 8'h6E;  // n
      4'd6:    c = 8'h74;  // t
      4'd7:    c = 8'h2D;  // -
      4'd8:    c = 8'h6C;  // l
      4'd9:    c = 8'h65;  // e
      4'd10:   c = 8'h6E;  // n
      4'd11:   c = 8'h67;  // g
      4'd12:   c = 8'h74;  // t
      4'd13:   c = 8'h68;  // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChVt) || (c == ChFf) ||
           (c == ChCr) || (c == ChLf);
  endfunction

endpackage

// File: rtl/core/cldf_value.sv
module cldf_value
  import cldf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  val_ctrl_t   ctrl_i,
  input  logic        neg_i,
  input  logic [31:0] max_body_i,
  output val_stat_t   stat_o
);

  logic [63:0] acc_q, acc_d;
  logic        ovf_q, ovf_d;
  logic [67:0] acc_x;
  logic [67:0] sum;
  logic [63:0] signed_val;

  // acc * 10 + digit, with the carry out of 64 bits kept
  assign acc_x = {4'b0, acc_q};
  assign sum   = (acc_x << 3) + (acc_x << 1) + {64'b0, ctrl_i.digit};

  always_comb begin
    acc_d = acc_q;
    ovf_d = ovf_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
      ovf_d = 1'b0;
    end else if (ctrl_i.acc_en) begin
      acc_d = sum[63:0];
      ovf_d = ovf_q | (|sum[67:64]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      ovf_q <= ovf_d;
    end
  end

  // A negative value wraps modulo 2^64
  assign signed_val = neg_i ? (64'd0 - acc_q) : acc_q;

  assign stat_o.overflow  = ovf_q;
  assign stat_o.too_large = (|signed_val[63:32]) || (signed_val[31:0] > max_body_i);
  assign stat_o.value     = signed_val[31:0];

endmodule

// File: rtl/core/content_length_message_deframer.sv
// Channel  Direction  Handshake                 Payload
// s_axis   in         s_axis_tvalid/tready      tdata: in_byte; tuser: at_end
// m_axis   out        m_axis_tvalid/tready      tdata: out_byte; tuser: kind; tlast: last
// cfg      in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// One input byte is taken per cycle while the input is ready; its result, if any, is
// loaded into the output register in the next cycle. The input is ready whenever that
// register is empty or is being drained, so throughput is one byte per cycle while the
// sink keeps up. A stalled sink holds the result and stops input only while it stays
// stalled. Reset clears all parser state and loads the default limits; no clearing pass.
module content_length_message_deframer
  import cldf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] at_end
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam line_st_t LineReset = '{colon: 1'b0, name_pos: 4'd0, name_match: 1'b1,
                                     vphase: VP_SKIP, vneg: 1'b0, vdigit: 1'b0};

  // Configuration registers
  logic [31:0] max_body_q;
  logic [15:0] max_line_q;

  // Parser state
  logic        in_body_q, in_body_d;
  logic [15:0] line_count_q, line_count_d;
  logic        prev_cr_q, prev_cr_d;
  line_st_t    line_q, line_d;
  logic        known_q, known_d;
  logic [31:0] rem_q, rem_d;

  // Output register
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  kind_e       out_kind_q;
  logic        out_last_q;

  logic        accept;
  logic        eof;
  logic [7:0]  b;
  logic        res_valid;
  logic [7:0]  res_byte;
  kind_e       res_kind;
  logic        res_last;
  logic        do_clear;
  logic        do_end;
  logic        end_eof;
  logic        len_zero;
  logic        hdr_match;
  feed_t       f_cr;
  feed_t       f_b;
  val_ctrl_t   val_ctrl;
  val_stat_t   val_stat;

  // One character into the name matcher or the value parser
  function automatic feed_t feed(input line_st_t st, input logic [7:0] c);
    feed_t      r;
    logic [7:0] lc;
    logic       dig;
    r.st  = st;
    r.acc = 1'b0;
    lc    = ((c >= ChUpA) && (c <= ChUpZ)) ? (c + CaseGap) : c;
    dig   = (c >= Ch0) && (c <= Ch9);
    if (!st.colon) begin
      if (c == ChColon) begin
        r.st.colon      = 1'b1;
        r.st.name_match = st.name_match && (st.name_pos == NameLen);
      end else begin
        if ((st.name_pos >= NameLen) || (lc != name_char(st.name_pos))) begin
          r.st.name_match = 1'b0;
        end
        if (st.name_pos < NamePosMax) begin
          r.st.name_pos = st.name_pos + 4'd1;
        end
      end
    end else begin
      if (st.vphase == VP_SKIP) begin
        if (is_space(c)) begin
          r.st.vphase = VP_SKIP;
        end else if ((c == ChPlus) || (c == ChMinus)) begin
          r.st.vneg   = (c == ChMinus);
          r.st.vphase = VP_SIGN;
        end else begin
          r.st.vphase = dig ? VP_DIGITS : VP_DONE;
        end
      end else if ((st.vphase == VP_SIGN) || (st.vphase == VP_DIGITS)) begin
        r.st.vphase = dig ? VP_DIGITS : VP_DONE;
      end
      if ((r.st.vphase == VP_DIGITS) && dig && (st.vphase != VP_SKIP || !is_space(c))
          && !(st.vphase == VP_SKIP && ((c == ChPlus) || (c == ChMinus)))) begin
        r.acc       = 1'b1;
        r.st.vdigit = 1'b1;
      end
    end
    return r;
  endfunction

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign eof           = s_axis_tuser;
  assign b             = s_axis_tdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= MaxBodyReset;
      max_line_q <= MaxLineReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMaxBody: max_body_q <= cfg_data_i;
        RegMaxLine: max_line_q <= cfg_data_i[15:0];
        default:    max_body_q <= max_body_q;
      endcase
    end
  end

  // Line ends: empty line after dropping a trailing CR, and the header match
  assign len_zero  = (line_count_q == 16'd0) || ((line_count_q == 16'd1) && prev_cr_q);
  assign hdr_match = line_q.colon && line_q.name_match;

  // A pending CR goes through first, then the new byte
  assign f_cr = feed(line_q, ChCr);
  assign f_b  = feed(prev_cr_q ? f_cr.st : line_q, b);

  // Next-state and result logic
  always_comb begin
    in_body_d    = in_body_q;
    line_count_d = line_count_q;
    prev_cr_d    = prev_cr_q;
    line_d       = line_q;
    known_d      = known_q;
    rem_d        = rem_q;
    res_valid    = 1'b0;
    res_byte     = 8'd0;
    res_kind     = KIND_BODY;
    res_last     = 1'b0;
    do_clear     = 1'b0;
    do_end       = 1'b0;
    end_eof      = 1'b0;
    val_ctrl     = '{clear: 1'b0, acc_en: 1'b0, digit: b[3:0]};

    if (accept) begin
      if (in_body_q) begin
        if (eof) begin
          res_valid = 1'b1;
          res_kind  = KIND_STREAM_END;
          res_last  = 1'b1;
        end else begin
          rem_d     = rem_q - 32'd1;
          res_valid = 1'b1;
          res_byte  = b;
          res_kind  = KIND_BODY;
          res_last  = (rem_q == 32'd1);
        end
      end else if (eof) begin
        if (line_count_q == 16'd0) begin
          res_valid = 1'b1;
          res_kind  = KIND_STREAM_END;
          res_last  = 1'b1;
        end else begin
          do_end  = 1'b1;
          end_eof = 1'b1;
        end
      end else if (b == ChLf) begin
        do_end = 1'b1;
      end else if (line_count_q >= max_line_q) begin
        res_valid = 1'b1;
        res_kind  = KIND_LINE_LONG;
        res_last  = 1'b1;
      end else begin
        line_count_d    = line_count_q + 16'd1;
        prev_cr_d       = (b == ChCr);
        if (b == ChCr) begin
          line_d = prev_cr_q ? f_cr.st : line_q;
        end else begin
          line_d          = f_b.st;
          val_ctrl.acc_en = f_b.acc;
        end
      end
    end

    // End of a header line
    if (do_end) begin
      if (len_zero) begin
        if (!known_q) begin
          res_valid = 1'b1;
          res_kind  = KIND_NO_LENGTH;
          res_last  = 1'b1;
        end else if (rem_q == 32'd0) begin
          res_valid = 1'b1;
          res_kind  = KIND_EMPTY;
          res_last  = 1'b1;
        end else if (end_eof) begin
          res_valid = 1'b1;
          res_kind  = KIND_STREAM_END;
          res_last  = 1'b1;
        end else begin
          do_clear  = 1'b1;
          in_body_d = 1'b1;
        end
      end else if (hdr_match && (!line_q.vdigit || val_stat.overflow)) begin
        res_valid = 1'b1;
        res_kind  = KIND_BAD_VALUE;
        res_last  = 1'b1;
      end else if (hdr_match && val_stat.too_large) begin
        res_valid = 1'b1;
        res_kind  = KIND_TOO_LARGE;
        res_last  = 1'b1;
      end else begin
        if (hdr_match) begin
          known_d = 1'b1;
          rem_d   = val_stat.value;
        end
        do_clear = 1'b1;
        if (end_eof) begin
          res_valid = 1'b1;
          res_kind  = KIND_STREAM_END;
          res_last  = 1'b1;
        end
      end
    end

    // Any closing result restarts at header parsing
    if (res_valid && res_last) begin
      do_clear  = 1'b1;
      in_body_d = 1'b0;
      known_d   = 1'b0;
      rem_d     = 32'd0;
    end

    if (do_clear) begin
      line_count_d    = 16'd0;
      prev_cr_d       = 1'b0;
      line_d          = LineReset;
      val_ctrl.clear  = 1'b1;
      val_ctrl.acc_en = 1'b0;
    end
  end

  // Decimal accumulator with overflow and limit check
  cldf_value u_value (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (val_ctrl),
    .neg_i      (line_q.vneg),
    .max_body_i (max_body_q),
    .stat_o     (val_stat)
  );

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q    <= 1'b0;
      line_count_q <= 16'd0;
      prev_cr_q    <= 1'b0;
      line_q       <= LineReset;
      known_q      <= 1'b0;
      rem_q        <= 32'd0;
    end else begin
      in_body_q    <= in_body_d;
      line_count_q <= line_count_d;
      prev_cr_q    <= prev_cr_d;
      line_q       <= line_d;
      known_q      <= known_d;
      rem_q        <= rem_d;
    end
  end

  // Output register: loads on a result, empties when the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_byte_q <= res_byte;
      out_kind_q <= res_kind;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule
